FILE: rtl/circular_deque_unit_macros.svh
// assertion macros used by the checker file
`ifndef CIRCULAR_DEQUE_UNIT_MACROS_SVH
`define CIRCULAR_DEQUE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define CDQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cdq check failed");

// next-cycle implication, sampled on clk, off during rst
`define CDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cdq check failed");

`endif

FILE: rtl/cdq_pkg.sv
package cdq_pkg;

  localparam int DEPTH  = 8;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 4;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_POP_FRONT  = 2'd1,
    OP_PUSH_FRONT = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // one access to the word store per cycle
  typedef struct packed {
    logic  we;
    logic  re;
    ptr_t  waddr;
    ptr_t  raddr;
    data_t wdata;
  } mem_req_t;

endpackage

FILE: rtl/cdq_store.sv
module cdq_store (
  input  logic             clk,
  input  cdq_pkg::mem_req_t req,
  output cdq_pkg::data_t    rdata
);
  import cdq_pkg::*;

  data_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: rtl/circular_deque_unit.sv
// channel  | handshake             | payload
// ---------+-----------------------+--------------------------------------------------------
// in       | in_valid / in_ready   | op[1:0], value[31:0] signed
// out      | out_valid / out_ready | status[1:0], popped_value[31:0] signed, occupancy[3:0]
//
// one request per cycle sustained while results are taken; each result passes through
// the read stage (registered read of the word store), then the result register.
// the front/rear positions and the count update in the accept cycle, so a
// request never waits on the one before it.
// rst (synchronous) clears positions, count and valid flags; the store is
// not cleared, since only written entries are ever popped.
// with out_ready low the result register holds, one more request can sit in
// the read stage, then in_ready drops until the result is taken.
module circular_deque_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cdq_pkg::OP_W-1:0]      op,
  input  logic signed [cdq_pkg::DATA_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cdq_pkg::ST_W-1:0]      status,
  output logic signed [cdq_pkg::DATA_W-1:0] popped_value,
  output logic [cdq_pkg::OCC_W-1:0]     occupancy
);
  import cdq_pkg::*;

  localparam ptr_t LAST_POS  = PTR_W'(DEPTH - 1);
  localparam cnt_t FULL_CNT  = CNT_W'(DEPTH);
  localparam cnt_t ONE_CNT   = CNT_W'(1);

  // wrap-around step forward and back
  function automatic ptr_t pos_next(input ptr_t p);
    return (p == LAST_POS) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t pos_prev(input ptr_t p);
    return (p == '0) ? LAST_POS : p - 1'b1;
  endfunction

  // deque state
  ptr_t front, front_next;
  ptr_t rear, rear_next;
  cnt_t cnt, cnt_next;

  // read stage: waits for the store read data
  logic    p_valid;
  status_t p_status;
  logic    p_pop_ok;
  cnt_t    p_cnt;

  // result register
  status_t out_status;
  data_t   out_popped;
  cnt_t    out_cnt;

  mem_req_t req;
  data_t    rd_data;
  status_t  st_in;
  logic     pop_ok_in;
  op_t      op_in;
  logic     accept;
  logic     out_free;
  logic     advance;
  logic     is_full;
  logic     is_empty;

  assign op_in    = op_t'(op);
  assign is_full  = (cnt == FULL_CNT);
  assign is_empty = (cnt == '0);

  // result slot frees when empty or taken this cycle
  assign out_free = !out_valid || out_ready;
  assign advance  = p_valid && out_free;
  assign in_ready = !p_valid || out_free;
  assign accept   = in_valid && in_ready;

  // pointer update and store access for the accepted request
  always_comb begin
    front_next = front;
    rear_next  = rear;
    cnt_next   = cnt;
    st_in      = ST_DONE;
    pop_ok_in  = 1'b0;
    req        = '0;
    req.wdata  = data_t'(value);
    if (accept) begin
      unique case (op_in)
        OP_PUSH_REAR, OP_PUSH_FRONT: begin
          if (is_full) begin
            st_in = ST_OVERFLOW;
          end else if (is_empty) begin
            // first word always lands at position zero
            front_next = '0;
            rear_next  = '0;
            cnt_next   = ONE_CNT;
            req.we     = 1'b1;
            req.waddr  = '0;
          end else if (op_in == OP_PUSH_REAR) begin
            rear_next = pos_next(rear);
            cnt_next  = cnt + 1'b1;
            req.we    = 1'b1;
            req.waddr = pos_next(rear);
          end else begin
            front_next = pos_prev(front);
            cnt_next   = cnt + 1'b1;
            req.we     = 1'b1;
            req.waddr  = pos_prev(front);
          end
        end
        OP_POP_FRONT, OP_POP_REAR: begin
          if (is_empty) begin
            st_in = ST_UNDERFLOW;
          end else begin
            pop_ok_in = 1'b1;
            req.re    = 1'b1;
            req.raddr = (op_in == OP_POP_FRONT) ? front : rear;
            if (cnt == ONE_CNT) begin
              // last word gone: positions return home
              front_next = '0;
              rear_next  = '0;
              cnt_next   = '0;
            end else if (op_in == OP_POP_FRONT) begin
              front_next = pos_next(front);
              cnt_next   = cnt - 1'b1;
            end else begin
              rear_next = pos_prev(rear);
              cnt_next  = cnt - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  cdq_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      rear      <= '0;
      cnt       <= '0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      front <= front_next;
      rear  <= rear_next;
      cnt   <= cnt_next;

      // read stage; rd_data holds while this stage waits, no new read issues
      if (accept) begin
        p_valid <= 1'b1;
      end else if (advance) begin
        p_valid <= 1'b0;
      end

      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      p_status <= st_in;
      p_pop_ok <= pop_ok_in;
      p_cnt    <= cnt_next;
    end
    if (advance) begin
      out_status <= p_status;
      out_popped <= p_pop_ok ? rd_data : '0;
      out_cnt    <= p_cnt;
    end
  end

  assign status       = out_status;
  assign popped_value = out_popped;
  // occupancy is reported modulo 16
  assign occupancy    = OCC_W'(out_cnt);

endmodule

FILE: rtl/cdq_checker.sv
`include "circular_deque_unit_macros.svh"

module cdq_assert_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cdq_pkg::ST_W-1:0]      status,
  input logic signed [cdq_pkg::DATA_W-1:0] popped_value,
  input logic [cdq_pkg::OCC_W-1:0]     occupancy
);
  import cdq_pkg::*;

  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

  // a stalled result keeps its payload
  `CDQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(popped_value) && $stable(occupancy))

  // failed requests never return a word
  `CDQ_ASSERT_NOW(a_fail_no_word, out_valid && status != ST_DONE, popped_value == '0)

  // overflow only with the store full
  `CDQ_ASSERT_NOW(a_ovf_full, out_valid && status == ST_OVERFLOW, occupancy == FULL_OCC)

  // underflow only with the deque empty
  `CDQ_ASSERT_NOW(a_udf_empty, out_valid && status == ST_UNDERFLOW, occupancy == '0)

endmodule

bind circular_deque_unit cdq_assert_checker u_cdq_checker (.*);
